FILE: design/sorted_key_position_table_defines.svh
// Assertion macros used by the checker file.
`ifndef SORTED_KEY_POSITION_TABLE_DEFINES_SVH
`define SORTED_KEY_POSITION_TABLE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define SKPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define SKPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/skpt_pkg.sv
// Package with types and constants of the sorted key position table.
package skpt_pkg;
   localparam int Capacity = 4096;
   localparam int KeyBits = 64;
   localparam int PosBits = 31;
   localparam int IdxBits = $clog2(Capacity);
   localparam int CntBits = IdxBits + 1;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_BUILD  = 2'd1,
      KIND_LOOKUP = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [KeyBits-1:0] key;
      logic [PosBits-1:0] pos_first;
      logic [PosBits-1:0] pos_second;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [PosBits-1:0] found_first;
      logic [PosBits-1:0] found_second;
   } rsp_type;

   // Port bundle from the control sequencer to the entry memory.
   typedef struct packed {
      logic               wr_en;
      logic [IdxBits-1:0] wr_addr;
      logic [KeyBits-1:0] wr_key;
      logic [PosBits-1:0] wr_first;
      logic [PosBits-1:0] wr_second;
      logic [IdxBits-1:0] rd_addr_a;
      logic [IdxBits-1:0] rd_addr_b;
   } entry_ctl_type;
endpackage

FILE: design/skpt_if.sv
// Valid/ready channel interface carrying one payload.
interface skpt_req_if;
   logic valid;
   logic ready;
   skpt_pkg::req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface skpt_rsp_if;
   logic valid;
   logic ready;
   skpt_pkg::rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

FILE: design/skpt_entry_mem.sv
// Entry memory: keys and positions, one write port and two registered read ports.
module skpt_entry_mem (
   input  logic                            clock,
   input  skpt_pkg::entry_ctl_type         ctl,
   output logic [skpt_pkg::KeyBits-1:0]    rd_key_a,
   output logic [skpt_pkg::KeyBits-1:0]    rd_key_b,
   output logic [skpt_pkg::PosBits-1:0]    rd_first_a,
   output logic [skpt_pkg::PosBits-1:0]    rd_second_a
);
   logic [skpt_pkg::KeyBits-1:0] key_mem [skpt_pkg::Capacity];
   logic [2*skpt_pkg::PosBits-1:0] pos_mem [skpt_pkg::Capacity];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         key_mem[ctl.wr_addr] <= ctl.wr_key;
         pos_mem[ctl.wr_addr] <= {ctl.wr_first, ctl.wr_second};
      end
      rd_key_a <= key_mem[ctl.rd_addr_a];
      rd_key_b <= key_mem[ctl.rd_addr_b];
      {rd_first_a, rd_second_a} <= pos_mem[ctl.rd_addr_a];
   end
endmodule

FILE: design/skpt_order_mem.sv
// Generic single-write, single-read RAM with registered read data.
module skpt_order_mem #(
   parameter int Depth = 4096,
   parameter int Width = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: design/sorted_key_position_table.sv
// Insert and clear respond through the done state; a lookup is a binary search in which each
// probe reads the order bank, then the entry memory, then compares keys; build sorts by
// bottom-up merge passes, bound by the single read ports of the index memories (two index
// banks ping-pong between passes).
// One request is worked at a time; a waiting response holds off the next request.
// Reset (synchronous) empties the table; memory contents are not cleared.
module sorted_key_position_table (
   input logic clock,
   input logic reset,
   skpt_req_if.sink   req,
   skpt_rsp_if.source rsp
);
   localparam int IB = skpt_pkg::IdxBits;
   localparam int CB = skpt_pkg::CntBits;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_L_RD, ST_L_WAIT, ST_L_CMP,
      ST_M_START, ST_M_RD, ST_M_WAIT, ST_M_CMP, ST_M_TAIL, ST_DONE
   } state_type;

   state_type state_ff;
   skpt_pkg::req_type cur_ff;
   logic [CB-1:0] entry_count_ff, built_count_ff;
   logic [CB:0] low_ff, high_ff;    // signed search bounds
   logic [CB-1:0] mid_ff;
   // merge bookkeeping
   logic [CB-1:0] width_ff, lo_ff, a_ff, b_ff, mid_end_ff, hi_end_ff, k_ff, init_ff;
   logic bank_ff;                   // bank currently holding the source order
   logic rsp_valid_ff;
   skpt_pkg::rsp_type rsp_ff;

   skpt_pkg::entry_ctl_type ectl;
   logic [skpt_pkg::KeyBits-1:0] key_a, key_b;
   logic [skpt_pkg::PosBits-1:0] first_a, second_a;
   logic [IB-1:0] ord_rd_a, ord_rd_b, ord0_a, ord0_b, ord1_a, ord1_b;
   logic [IB-1:0] ord_wr_data;
   logic [IB-1:0] ord_wr_addr;
   logic ord0_we, ord1_we;
   logic [IB-1:0] ord_ra_addr, ord_rb_addr;
   logic [IB-1:0] ent_a_ff, ent_b_ff;
   logic [1:0] rd_phase_ff;

   // two banks, each as two single-read copies so a and b can be read together
   skpt_order_mem #(.Depth(skpt_pkg::Capacity), .Width(IB)) u_ord0a (
      .clock(clock), .wr_en(ord0_we), .wr_addr(ord_wr_addr), .wr_data(ord_wr_data),
      .rd_addr(ord_ra_addr), .rd_data(ord0_a));
   skpt_order_mem #(.Depth(skpt_pkg::Capacity), .Width(IB)) u_ord0b (
      .clock(clock), .wr_en(ord0_we), .wr_addr(ord_wr_addr), .wr_data(ord_wr_data),
      .rd_addr(ord_rb_addr), .rd_data(ord0_b));
   skpt_order_mem #(.Depth(skpt_pkg::Capacity), .Width(IB)) u_ord1a (
      .clock(clock), .wr_en(ord1_we), .wr_addr(ord_wr_addr), .wr_data(ord_wr_data),
      .rd_addr(ord_ra_addr), .rd_data(ord1_a));
   skpt_order_mem #(.Depth(skpt_pkg::Capacity), .Width(IB)) u_ord1b (
      .clock(clock), .wr_en(ord1_we), .wr_addr(ord_wr_addr), .wr_data(ord_wr_data),
      .rd_addr(ord_rb_addr), .rd_data(ord1_b));

   skpt_entry_mem u_entry (
      .clock(clock), .ctl(ectl), .rd_key_a(key_a), .rd_key_b(key_b),
      .rd_first_a(first_a), .rd_second_a(second_a));

   assign ord_rd_a = bank_ff ? ord1_a : ord0_a;
   assign ord_rd_b = bank_ff ? ord1_b : ord0_b;

   logic accept;
   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   logic a_live, b_live, take_b;
   assign a_live = a_ff < mid_end_ff;
   assign b_live = b_ff < hi_end_ff;
   assign take_b = !a_live || (b_live && (key_b < key_a));

   // Order memory addressing: search reads the source bank at mid once mid is
   // registered; merge reads positions a and b; writes target the other bank
   // (init writes bank 0).
   always_comb begin
      ord_ra_addr = (state_ff == ST_L_WAIT || state_ff == ST_L_CMP) ? mid_ff[IB-1:0]
                                                                    : a_ff[IB-1:0];
      ord_rb_addr = b_ff[IB-1:0];
      ord0_we = 1'b0;
      ord1_we = 1'b0;
      ord_wr_addr = k_ff[IB-1:0];
      ord_wr_data = take_b ? ent_b_ff : ent_a_ff;
      if (state_ff == ST_INIT) begin
         ord0_we = 1'b1;
         ord_wr_addr = init_ff[IB-1:0];
         ord_wr_data = init_ff[IB-1:0];
      end else if (state_ff == ST_M_CMP || state_ff == ST_M_TAIL) begin
         ord0_we = bank_ff;
         ord1_we = !bank_ff;
      end
   end

   always_comb begin
      ectl.wr_en = accept && (req.data.kind == skpt_pkg::KIND_INSERT)
                   && (entry_count_ff < CB'(skpt_pkg::Capacity));
      ectl.wr_addr = entry_count_ff[IB-1:0];
      ectl.wr_key = req.data.key;
      ectl.wr_first = req.data.pos_first;
      ectl.wr_second = req.data.pos_second;
      ectl.rd_addr_a = ord_rd_a;
      ectl.rd_addr_b = ord_rd_b;
   end

   logic [CB:0] mid_sum;
   logic [CB:0] next_mid;
   always_comb begin
      mid_sum = low_ff + high_ff;
      next_mid = mid_sum >> 1;  // low, high non-negative while searching
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         entry_count_ff <= '0;
         built_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         bank_ff <= 1'b0;
         rd_phase_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cur_ff <= req.data;
                  rsp_ff <= '0;
                  unique case (req.data.kind)
                     skpt_pkg::KIND_INSERT: begin
                        if (entry_count_ff < CB'(skpt_pkg::Capacity)) begin
                           entry_count_ff <= entry_count_ff + 1'b1;
                        end else begin
                           rsp_ff.status <= skpt_pkg::STATUS_FULL;
                        end
                        state_ff <= ST_DONE;
                     end
                     skpt_pkg::KIND_BUILD: begin
                        init_ff <= '0;
                        bank_ff <= 1'b0;
                        state_ff <= ST_INIT;
                     end
                     skpt_pkg::KIND_LOOKUP: begin
                        rsp_ff.status <= skpt_pkg::STATUS_MISS;
                        low_ff <= '0;
                        high_ff <= {1'b0, built_count_ff} - 1'b1;
                        state_ff <= ST_L_RD;
                     end
                     default: begin
                        entry_count_ff <= '0;
                        built_count_ff <= '0;
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            // Search: ord read, then entry read, then compare.
            ST_L_RD: begin
               if ($signed(low_ff) > $signed(high_ff)) begin
                  state_ff <= ST_DONE;
               end else begin
                  mid_ff <= next_mid[CB-1:0];
                  state_ff <= ST_L_WAIT;
               end
            end
            ST_L_WAIT: state_ff <= ST_L_CMP;
            ST_L_CMP: begin
               if (rd_phase_ff == 2'd0) begin
                  rd_phase_ff <= 2'd1;  // entry memory read is in flight
               end else begin
                  rd_phase_ff <= 2'd0;
                  if (key_a == cur_ff.key) begin
                     rsp_ff.status <= skpt_pkg::STATUS_OK;
                     rsp_ff.found_first <= first_a;
                     rsp_ff.found_second <= second_a;
                     state_ff <= ST_DONE;
                  end else begin
                     if (key_a < cur_ff.key) begin
                        low_ff <= {1'b0, mid_ff} + 1'b1;
                     end else begin
                        high_ff <= {1'b0, mid_ff} - 1'b1;
                     end
                     state_ff <= ST_L_RD;
                  end
               end
            end
            ST_INIT: begin
               if (init_ff == entry_count_ff) begin
                  width_ff <= CB'(1);
                  lo_ff <= '0;
                  state_ff <= ST_M_START;
               end else begin
                  init_ff <= init_ff + 1'b1;
               end
            end
            ST_M_START: begin
               if (width_ff >= entry_count_ff) begin
                  built_count_ff <= entry_count_ff;
                  state_ff <= ST_DONE;
               end else if (lo_ff >= entry_count_ff) begin
                  bank_ff <= !bank_ff;
                  width_ff <= width_ff << 1;
                  lo_ff <= '0;
               end else begin
                  a_ff <= lo_ff;
                  k_ff <= lo_ff;
                  b_ff <= ((entry_count_ff - lo_ff) > width_ff) ? lo_ff + width_ff
                                                                 : entry_count_ff;
                  mid_end_ff <= ((entry_count_ff - lo_ff) > width_ff) ? lo_ff + width_ff
                                                                       : entry_count_ff;
                  hi_end_ff <= (((entry_count_ff - lo_ff) >> 1) > width_ff - 1'b1
                                && (entry_count_ff - lo_ff) >= (width_ff << 1))
                               ? lo_ff + (width_ff << 1) : entry_count_ff;
                  state_ff <= ST_M_RD;
               end
            end
            ST_M_RD: begin
               if (!a_live && !b_live) begin
                  lo_ff <= hi_end_ff;
                  state_ff <= ST_M_START;
               end else begin
                  state_ff <= ST_M_WAIT;
               end
            end
            ST_M_WAIT: begin
               ent_a_ff <= ord_rd_a;
               ent_b_ff <= ord_rd_b;
               state_ff <= ST_M_TAIL;
            end
            // Entry keys for ent_a/ent_b are now being read.
            ST_M_TAIL: state_ff <= ST_M_CMP;
            ST_M_CMP: begin
               k_ff <= k_ff + 1'b1;
               if (take_b) begin
                  b_ff <= b_ff + 1'b1;
               end else begin
                  a_ff <= a_ff + 1'b1;
               end
               state_ff <= ST_M_RD;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

FILE: design/skpt_checker.sv
// Port-level checker for the sorted key position table, bound to the top level.
`include "sorted_key_position_table_defines.svh"
module skpt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_status,
   input logic [skpt_pkg::PosBits-1:0] rsp_found_first
);
   `SKPT_ASSERT_IMP(a_one_at_a_time, clock, reset, rsp_valid, !req_ready, "request while busy")
   `SKPT_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready, "back to back")
   `SKPT_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_status <= skpt_pkg::STATUS_MISS, "bad status")
   `SKPT_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && rsp_status != skpt_pkg::STATUS_OK, rsp_found_first == '0, "position on a miss")
endmodule

bind sorted_key_position_table skpt_checker u_skpt_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data.status),
   .rsp_found_first(rsp.data.found_first));

FILE: test/tb_sorted_key_position_table.sv
// Testbench for the sorted key position table: random and directed requests, checked responses.
module tb_sorted_key_position_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 3000000;

   logic clock;
   logic reset;

   skpt_req_if req_ch();
   skpt_rsp_if rsp_ch();

   sorted_key_position_table u_top (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   // Table mirror used to predict responses.
   logic [skpt_pkg::KeyBits-1:0] tbl_key [skpt_pkg::Capacity];
   logic [skpt_pkg::PosBits-1:0] tbl_first [skpt_pkg::Capacity];
   logic [skpt_pkg::PosBits-1:0] tbl_second [skpt_pkg::Capacity];
   int unsigned        tbl_order [skpt_pkg::Capacity];
   int unsigned        tbl_count;
   int unsigned        tbl_built;

   skpt_pkg::req_type pending_reqs[$];
   skpt_pkg::rsp_type expected_rsps[$];
   int unsigned mismatch_count;
   int unsigned cycle_count;
   bit          sender_hold;
   bit          calm_phase;
   bit          stim_done;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stable insertion sort of the order index; keeps insertion order on ties.
   task automatic sort_table();
      int unsigned i;
      int          j;
      int unsigned v;
      for (i = 0; i < tbl_count; i++) tbl_order[i] = i;
      for (i = 1; i < tbl_count; i++) begin
         v = tbl_order[i];
         j = int'(i) - 1;
         while (j >= 0 && tbl_key[tbl_order[j]] > tbl_key[v]) begin
            tbl_order[j + 1] = tbl_order[j];
            j--;
         end
         tbl_order[j + 1] = v;
      end
   endtask

   task automatic predict_table(input skpt_pkg::req_type r);
      skpt_pkg::rsp_type res;
      int          low;
      int          high;
      int          mid;
      int unsigned e;
      res = '0;
      res.status = skpt_pkg::STATUS_OK;
      case (skpt_pkg::kind_type'(r.kind))
         skpt_pkg::KIND_INSERT: begin
            if (tbl_count < skpt_pkg::Capacity) begin
               tbl_key[tbl_count] = r.key;
               tbl_first[tbl_count] = r.pos_first;
               tbl_second[tbl_count] = r.pos_second;
               tbl_count++;
            end else begin
               res.status = skpt_pkg::STATUS_FULL;
            end
         end
         skpt_pkg::KIND_BUILD: begin
            sort_table();
            tbl_built = tbl_count;
         end
         skpt_pkg::KIND_LOOKUP: begin
            low = 0;
            high = int'(tbl_built) - 1;
            res.status = skpt_pkg::STATUS_MISS;
            while (low <= high) begin
               mid = (low + high) / 2;
               e = tbl_order[mid];
               if (tbl_key[e] == r.key) begin
                  res.status = skpt_pkg::STATUS_OK;
                  res.found_first = tbl_first[e];
                  res.found_second = tbl_second[e];
                  break;
               end else if (tbl_key[e] < r.key) begin
                  low = mid + 1;
               end else begin
                  high = mid - 1;
               end
            end
         end
         default: begin
            tbl_count = 0;
            tbl_built = 0;
         end
      endcase
      expected_rsps.push_back(res);
   endtask

   function automatic skpt_pkg::req_type make_req(skpt_pkg::kind_type k,
                                                  logic [skpt_pkg::KeyBits-1:0] key);
      skpt_pkg::req_type r;
      r.kind = k;
      r.key = key;
      r.pos_first = skpt_pkg::PosBits'({$urandom, $urandom});
      r.pos_second = skpt_pkg::PosBits'({$urandom, $urandom});
      return r;
   endfunction

   function automatic logic [skpt_pkg::KeyBits-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   // Stimulus.
   initial begin
      logic [skpt_pkg::KeyBits-1:0] used_keys[$];
      logic [skpt_pkg::KeyBits-1:0] k;
      int                 n;
      int                 i;
      int                 j;
      skpt_pkg::req_type  r;
      stim_done = 1'b0;
      sender_hold = 1'b0;
      calm_phase = 1'b0;
      // Directed: lookup before any build, empty build, extremes, duplicates.
      pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, '0));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_BUILD, '0));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, '1));
      r = make_req(skpt_pkg::KIND_INSERT, '1);
      r.pos_first = '1;
      r.pos_second = '1;
      pending_reqs.push_back(r);
      r = make_req(skpt_pkg::KIND_INSERT, '0);
      r.pos_first = '0;
      r.pos_second = '0;
      pending_reqs.push_back(r);
      pending_reqs.push_back(make_req(skpt_pkg::KIND_INSERT, 64'h5555_aaaa_0f0f_f0f0));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_INSERT, 64'h5555_aaaa_0f0f_f0f0));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_INSERT, 64'h8000_0000_0000_0000));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, '1));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_BUILD, '0));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, '1));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, '0));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, 64'h5555_aaaa_0f0f_f0f0));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, 64'h8000_0000_0000_0000));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, 64'h1234));
      // Inserts after a build stay unsearched until the next build.
      pending_reqs.push_back(make_req(skpt_pkg::KIND_INSERT, 64'h1234));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, 64'h1234));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_CLEAR, '1));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, '1));

      @(posedge clock);
      while (reset) @(posedge clock);
      // A larger table with many repeated keys.
      for (i = 0; i < 64; i++) begin
         r = make_req(skpt_pkg::KIND_INSERT, skpt_pkg::KeyBits'($urandom_range(0, 40)));
         pending_reqs.push_back(r);
      end
      pending_reqs.push_back(make_req(skpt_pkg::KIND_BUILD, '0));
      for (i = 0; i < 20; i++)
         pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP,
                                         skpt_pkg::KeyBits'($urandom_range(0, 40))));
      pending_reqs.push_back(make_req(skpt_pkg::KIND_CLEAR, '0));

      // Random phases: small tables, build, mostly lookups of inserted keys.
      for (j = 0; j < 45; j++) begin
         if (j == 20) begin
            // Hold the sender until the block has drained.
            while (pending_reqs.size() != 0) @(posedge clock);
            sender_hold = 1'b1;
            while (expected_rsps.size() != 0) @(posedge clock);
            sender_hold = 1'b0;
         end
         calm_phase = (j >= 30 && j < 34);
         used_keys.delete();
         n = $urandom_range(0, 8);
         for (i = 0; i < n; i++) begin
            k = ($urandom_range(0, 3) == 0) ? skpt_pkg::KeyBits'($urandom_range(0, 7))
                                            : rand_key();
            if (used_keys.size() != 0 && $urandom_range(0, 4) == 0)
               k = used_keys[$urandom_range(0, used_keys.size() - 1)];
            used_keys.push_back(k);
            pending_reqs.push_back(make_req(skpt_pkg::KIND_INSERT, k));
         end
         if ($urandom_range(0, 9) != 0)
            pending_reqs.push_back(make_req(skpt_pkg::KIND_BUILD, rand_key()));
         for (i = 0; i < 10; i++) begin
            if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
               k = used_keys[$urandom_range(0, used_keys.size() - 1)];
            else
               k = rand_key();
            pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, k));
         end
         if ($urandom_range(0, 3) == 0)
            pending_reqs.push_back(make_req(skpt_pkg::KIND_INSERT, rand_key()));
         if ($urandom_range(0, 2) == 0)
            pending_reqs.push_back(make_req(skpt_pkg::KIND_LOOKUP, rand_key()));
         pending_reqs.push_back(make_req(skpt_pkg::KIND_CLEAR, rand_key()));
      end
      while (pending_reqs.size() != 0 || req_ch.valid) @(posedge clock);
      stim_done = 1'b1;
   end

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_table(req_ch.data);
         if ((req_ch.valid && !req_ch.ready)) begin
            // Hold the current request.
         end else if (pending_reqs.size() != 0 && !sender_hold
                      && (calm_phase || $urandom_range(0, 99) >= 23)) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pending_reqs.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response monitor and ready generator.
   always @(posedge clock) begin
      skpt_pkg::rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         mismatch_count <= 0;
      end else begin
         rsp_ch.ready <= calm_phase || ($urandom_range(0, 99) >= 23);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               if (mismatch_count < 10)
                  $display("Unexpected response %p", rsp_ch.data);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_ch.data !== want) begin
                  if (mismatch_count < 10)
                     $display("Mismatch: expected status %0d first %0d second %0d, got %0d %0d %0d",
                              want.status, want.found_first, want.found_second,
                              rsp_ch.data.status, rsp_ch.data.found_first,
                              rsp_ch.data.found_second);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

   // Reset, cycle limit and end of run.
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      cycle_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (!(stim_done && expected_rsps.size() == 0) && cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      if (cycle_count >= CycleLimit) begin
         $display("Some tests failed");
      end else begin
         repeat (50) @(posedge clock);
         if (mismatch_count == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
         else
            $display("Some tests failed");
      end
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+design
design/skpt_pkg.sv
design/skpt_if.sv
design/skpt_entry_mem.sv
design/skpt_order_mem.sv
design/sorted_key_position_table.sv
design/skpt_checker.sv
test/tb_sorted_key_position_table.sv
